>>> hw/rtl/tty_input_line_discipline_defines.svh
// Assertion macros for the terminal input line discipline RTL
`ifndef TTY_INPUT_LINE_DISCIPLINE_DEFINES_SVH
`define TTY_INPUT_LINE_DISCIPLINE_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset
`define TTYLD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define TTYLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ttyld_pkg.sv
// Types, constants and helpers for the terminal input line discipline
package ttyld_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int LINE_DEPTH  = 1024;
    localparam int LINE_SLOTS  = 128;
    localparam int CMDQ_DEPTH  = 4;

    localparam int SA  = $clog2(STORE_DEPTH);
    localparam int FW  = $clog2(STORE_DEPTH + 1);
    localparam int EA  = $clog2(LINE_DEPTH);
    localparam int LW  = $clog2(LINE_DEPTH + 2);
    localparam int QA  = $clog2(LINE_SLOTS);
    localparam int QCW = $clog2(LINE_SLOTS + 1);
    localparam int CQA = $clog2(CMDQ_DEPTH);

    localparam logic [2:0] CFG_INPUT_FLAGS = 3'd0;
    localparam logic [2:0] CFG_INTR_CHAR   = 3'd1;
    localparam logic [2:0] CFG_QUIT_CHAR   = 3'd2;
    localparam logic [2:0] CFG_SUSP_CHAR   = 3'd3;
    localparam logic [2:0] CFG_EOF_CHAR    = 3'd4;

    localparam logic [5:0] RST_FLAGS = 6'd50;
    localparam logic [7:0] RST_INTR  = 8'h03;
    localparam logic [7:0] RST_QUIT  = 8'h1C;
    localparam logic [7:0] RST_SUSP  = 8'h1A;
    localparam logic [7:0] RST_EOF   = 8'h04;

    localparam int FL_IGNCR = 0;
    localparam int FL_ICRNL = 1;
    localparam int FL_INLCR = 2;
    localparam int FL_ISIG  = 3;
    localparam int FL_CANON = 4;
    localparam int FL_ECHO  = 5;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_ROOM = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    localparam logic [1:0] SIG_INTR = 2'd0;
    localparam logic [1:0] SIG_QUIT = 2'd1;
    localparam logic [1:0] SIG_SUSP = 2'd2;

    typedef enum logic [2:0] {
        CMD_IGNORED, CMD_SIGNAL, CMD_RAW_PUSH, CMD_ERASE,
        CMD_COMMIT, CMD_EDIT_PUT, CMD_READ_RAW, CMD_READ_CANON
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic [1:0] sig_kind;
        logic       echo;
        logic       newline;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_COPY_RD, S_COPY_WR, S_COMMIT_END, S_QWAIT, S_RD_WAIT, S_OUT
    } back_state_t;

    typedef struct packed {
        logic [FW-1:0]  fill;
        logic [LW-1:0]  edit_len;
        logic [QCW-1:0] qcount;
    } back_stat_t;

    // Echo character k of a command's echo run
    function automatic logic [7:0] echo_char(cmd_t c, logic [1:0] k);
        logic [7:0] letter;
        letter = (c.sig_kind == SIG_INTR) ? CH_C : ((c.sig_kind == SIG_QUIT) ? CH_BSL : CH_Z);
        unique case (c.kind)
            CMD_SIGNAL: echo_char = (k == 2'd0) ? CH_CARET : ((k == 2'd1) ? letter : CH_NL);
            CMD_ERASE:  echo_char = (k == 2'd1) ? CH_SPACE : CH_BS;
            default:    echo_char = c.data;
        endcase
    endfunction

endpackage

>>> hw/rtl/ttyld_front.sv
// Front end: configuration registers, input acceptance and byte classification
module ttyld_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [7:0]       cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic [0:0]       s_tuser,
    input  logic             q_full,
    output logic             q_push,
    output ttyld_pkg::cmd_t  q_din
);

    logic [5:0] flags_reg;
    logic [7:0] intr_reg, quit_reg, susp_reg, eof_reg;
    logic [7:0] b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= ttyld_pkg::RST_FLAGS;
            intr_reg  <= ttyld_pkg::RST_INTR;
            quit_reg  <= ttyld_pkg::RST_QUIT;
            susp_reg  <= ttyld_pkg::RST_SUSP;
            eof_reg   <= ttyld_pkg::RST_EOF;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ttyld_pkg::CFG_INPUT_FLAGS: flags_reg <= cfg_wdata[5:0];
                ttyld_pkg::CFG_INTR_CHAR:   intr_reg  <= cfg_wdata;
                ttyld_pkg::CFG_QUIT_CHAR:   quit_reg  <= cfg_wdata;
                ttyld_pkg::CFG_SUSP_CHAR:   susp_reg  <= cfg_wdata;
                ttyld_pkg::CFG_EOF_CHAR:    eof_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        if (flags_reg[ttyld_pkg::FL_ICRNL] && s_tdata == ttyld_pkg::CH_CR)
            b = ttyld_pkg::CH_NL;
        else if (flags_reg[ttyld_pkg::FL_INLCR] && s_tdata == ttyld_pkg::CH_NL)
            b = ttyld_pkg::CH_CR;
        else
            b = s_tdata;
    end

    // Classify in priority order: read, ignored CR, signal, raw, erase, commit, edit
    always_comb begin
        q_din.data     = b;
        q_din.echo     = flags_reg[ttyld_pkg::FL_ECHO];
        q_din.newline  = (b == ttyld_pkg::CH_NL);
        q_din.sig_kind = ttyld_pkg::SIG_SUSP;
        if (b == intr_reg)
            q_din.sig_kind = ttyld_pkg::SIG_INTR;
        else if (b == quit_reg)
            q_din.sig_kind = ttyld_pkg::SIG_QUIT;
        priority if (s_tuser[0])
            q_din.kind = flags_reg[ttyld_pkg::FL_CANON] ? ttyld_pkg::CMD_READ_CANON
                                                         : ttyld_pkg::CMD_READ_RAW;
        else if (flags_reg[ttyld_pkg::FL_IGNCR] && s_tdata == ttyld_pkg::CH_CR)
            q_din.kind = ttyld_pkg::CMD_IGNORED;
        else if (flags_reg[ttyld_pkg::FL_ISIG] &&
                 (b == intr_reg || b == quit_reg || b == susp_reg))
            q_din.kind = ttyld_pkg::CMD_SIGNAL;
        else if (!flags_reg[ttyld_pkg::FL_CANON])
            q_din.kind = ttyld_pkg::CMD_RAW_PUSH;
        else if (b == ttyld_pkg::CH_BS || b == ttyld_pkg::CH_DEL)
            q_din.kind = ttyld_pkg::CMD_ERASE;
        else if (b == eof_reg || b == ttyld_pkg::CH_NL)
            q_din.kind = ttyld_pkg::CMD_COMMIT;
        else
            q_din.kind = ttyld_pkg::CMD_EDIT_PUT;
    end

endmodule

>>> hw/rtl/ttyld_cmd_fifo.sv
// Short command queue between the front end and the back end
module ttyld_cmd_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ttyld_pkg::cmd_t  din,
    input  logic             pop,
    output ttyld_pkg::cmd_t  dout,
    output logic             full,
    output logic             empty
);

    ttyld_pkg::cmd_t             mem [ttyld_pkg::CMDQ_DEPTH];
    logic [ttyld_pkg::CQA-1:0]   wr_reg, rd_reg;
    logic [ttyld_pkg::CQA:0]     cnt_reg;

    assign full  = (cnt_reg == (ttyld_pkg::CQA + 1)'(ttyld_pkg::CMDQ_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= din;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (ttyld_pkg::CQA + 1)'(push) - (ttyld_pkg::CQA + 1)'(pop);
        end
    end

endmodule

>>> hw/rtl/ttyld_back.sv
// Back end: stores, line editing, commit copy, reads and result output
module ttyld_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  ttyld_pkg::cmd_t       q_dout,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic                  m_tlast,
    output ttyld_pkg::back_stat_t stat
);

    localparam int SA = ttyld_pkg::SA;
    localparam int FW = ttyld_pkg::FW;
    localparam int EA = ttyld_pkg::EA;
    localparam int LW = ttyld_pkg::LW;
    localparam int QA = ttyld_pkg::QA;
    localparam int QCW = ttyld_pkg::QCW;

    logic [7:0]    store_mem [ttyld_pkg::STORE_DEPTH];
    logic [7:0]    edit_mem  [ttyld_pkg::LINE_DEPTH];
    logic [LW-1:0] lq_mem    [ttyld_pkg::LINE_SLOTS];
    logic [7:0]    store_q, edit_q;
    logic [LW-1:0] lq_q;

    ttyld_pkg::back_state_t state_reg, state_next;
    ttyld_pkg::cmd_t        cmd_reg, cmd_next;
    logic [SA-1:0]  rpos_reg, rpos_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [LW-1:0]  elen_reg, elen_next, cidx_reg, cidx_next, qlen_reg, qlen_next;
    logic [QA-1:0]  qhead_reg, qhead_next, qtail_reg, qtail_next;
    logic [QCW-1:0] qcnt_reg, qcnt_next;
    logic [1:0]     ost_reg, ost_next, nec_reg, nec_next, k_reg, k_next;
    logic           orv_reg, orv_next, olend_reg, olend_next;
    logic [7:0]     orb_reg, orb_next;

    logic           st_we, ed_we, lq_we;
    logic [SA-1:0]  st_waddr;
    logic [7:0]     st_wdata;
    logic [QA-1:0]  lq_waddr;
    logic [LW-1:0]  lq_wdata, needed, qdec;
    logic [FW:0]    room;
    logic           commit_ok, last_k, echo_v;

    always_ff @(posedge aclk) begin
        if (st_we) store_mem[st_waddr] <= st_wdata;
        store_q <= store_mem[rpos_reg];
    end

    always_ff @(posedge aclk) begin
        if (ed_we) edit_mem[elen_reg[EA-1:0]] <= cmd_reg.data;
        edit_q <= edit_mem[cidx_reg[EA-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (lq_we) lq_mem[lq_waddr] <= lq_wdata;
        lq_q <= lq_mem[qtail_reg];
    end

    assign st_waddr  = rpos_reg + fill_reg[SA-1:0];
    assign needed    = elen_reg + LW'(cmd_reg.newline);
    assign room      = (FW + 1)'(ttyld_pkg::STORE_DEPTH) - (FW + 1)'(fill_reg);
    assign commit_ok = ((FW + 1)'(needed) <= room) &&
                       (qcnt_reg < QCW'(ttyld_pkg::LINE_SLOTS));
    assign qdec      = qlen_reg - 1'b1;
    assign last_k    = (k_reg == ((nec_reg == 2'd0) ? 2'd0 : nec_reg - 2'd1));
    assign echo_v    = (k_reg < nec_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ttyld_pkg::S_IDLE: if (!q_empty) state_next = ttyld_pkg::S_EXEC;
            ttyld_pkg::S_EXEC: begin
                state_next = ttyld_pkg::S_OUT;
                if (cmd_reg.kind == ttyld_pkg::CMD_COMMIT && commit_ok)
                    state_next = (elen_reg != '0) ? ttyld_pkg::S_COPY_RD
                                                  : ttyld_pkg::S_COMMIT_END;
                else if (cmd_reg.kind == ttyld_pkg::CMD_READ_RAW && fill_reg != '0)
                    state_next = ttyld_pkg::S_RD_WAIT;
                else if (cmd_reg.kind == ttyld_pkg::CMD_READ_CANON && qcnt_reg != '0)
                    state_next = ttyld_pkg::S_QWAIT;
            end
            ttyld_pkg::S_COPY_RD: state_next = ttyld_pkg::S_COPY_WR;
            ttyld_pkg::S_COPY_WR:
                state_next = (cidx_reg + 1'b1 == elen_reg) ? ttyld_pkg::S_COMMIT_END
                                                           : ttyld_pkg::S_COPY_RD;
            ttyld_pkg::S_COMMIT_END: state_next = ttyld_pkg::S_OUT;
            ttyld_pkg::S_QWAIT:
                state_next = (lq_q != '0 && fill_reg != '0) ? ttyld_pkg::S_RD_WAIT
                                                            : ttyld_pkg::S_OUT;
            ttyld_pkg::S_RD_WAIT: state_next = ttyld_pkg::S_OUT;
            ttyld_pkg::S_OUT: if (m_tready && last_k) state_next = ttyld_pkg::S_IDLE;
            default: state_next = ttyld_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd_next = cmd_reg;   rpos_next = rpos_reg;  fill_next = fill_reg;
        elen_next = elen_reg; cidx_next = cidx_reg;  qlen_next = qlen_reg;
        qhead_next = qhead_reg; qtail_next = qtail_reg; qcnt_next = qcnt_reg;
        ost_next = ost_reg;   nec_next = nec_reg;    k_next = k_reg;
        orv_next = orv_reg;   orb_next = orb_reg;    olend_next = olend_reg;
        q_pop = 1'b0; st_we = 1'b0; st_wdata = cmd_reg.data; ed_we = 1'b0;
        lq_we = 1'b0; lq_waddr = qhead_reg; lq_wdata = needed;
        unique case (state_reg)
            ttyld_pkg::S_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_dout;
                end
            end
            ttyld_pkg::S_EXEC: begin
                ost_next = ttyld_pkg::ST_DONE; nec_next = 2'd0; k_next = 2'd0;
                orv_next = 1'b0; orb_next = '0; olend_next = 1'b0;
                unique case (cmd_reg.kind)
                    ttyld_pkg::CMD_IGNORED: ;
                    ttyld_pkg::CMD_SIGNAL: begin
                        nec_next = cmd_reg.echo ? 2'd3 : 2'd0;
                        rpos_next = '0; fill_next = '0; elen_next = '0;
                        qhead_next = '0; qtail_next = '0; qcnt_next = '0;
                    end
                    ttyld_pkg::CMD_RAW_PUSH: begin
                        if (fill_reg == FW'(ttyld_pkg::STORE_DEPTH)) begin
                            ost_next = ttyld_pkg::ST_NO_ROOM;
                        end else begin
                            st_we     = 1'b1;
                            fill_next = fill_reg + 1'b1;
                            nec_next  = cmd_reg.echo ? 2'd1 : 2'd0;
                        end
                    end
                    ttyld_pkg::CMD_ERASE: begin
                        if (elen_reg != '0) begin
                            elen_next = elen_reg - 1'b1;
                            nec_next  = cmd_reg.echo ? 2'd3 : 2'd0;
                        end
                    end
                    ttyld_pkg::CMD_EDIT_PUT: begin
                        if (elen_reg >= LW'(ttyld_pkg::LINE_DEPTH)) begin
                            ost_next = ttyld_pkg::ST_NO_ROOM;
                        end else begin
                            ed_we     = 1'b1;
                            elen_next = elen_reg + 1'b1;
                            nec_next  = cmd_reg.echo ? 2'd1 : 2'd0;
                        end
                    end
                    ttyld_pkg::CMD_COMMIT: begin
                        if (!commit_ok) ost_next = ttyld_pkg::ST_NO_ROOM;
                        cidx_next = '0;
                    end
                    ttyld_pkg::CMD_READ_RAW:
                        if (fill_reg == '0) ost_next = ttyld_pkg::ST_EMPTY;
                    ttyld_pkg::CMD_READ_CANON:
                        if (qcnt_reg == '0) ost_next = ttyld_pkg::ST_EMPTY;
                    default: ;
                endcase
            end
            ttyld_pkg::S_COPY_RD: ;
            ttyld_pkg::S_COPY_WR: begin
                st_we     = 1'b1;
                st_wdata  = edit_q;
                fill_next = fill_reg + 1'b1;
                cidx_next = cidx_reg + 1'b1;
            end
            ttyld_pkg::S_COMMIT_END: begin
                if (cmd_reg.newline) begin
                    st_we     = 1'b1;
                    st_wdata  = ttyld_pkg::CH_NL;
                    fill_next = fill_reg + 1'b1;
                end
                lq_we      = 1'b1;
                qhead_next = qhead_reg + 1'b1;
                qcnt_next  = qcnt_reg + 1'b1;
                elen_next  = '0;
            end
            ttyld_pkg::S_QWAIT: begin
                qlen_next = lq_q;
                if (lq_q == '0) begin
                    olend_next = 1'b1;
                    qtail_next = qtail_reg + 1'b1;
                    qcnt_next  = qcnt_reg - 1'b1;
                end else if (fill_reg == '0) begin
                    ost_next = ttyld_pkg::ST_EMPTY;
                end
            end
            ttyld_pkg::S_RD_WAIT: begin
                orv_next  = 1'b1;
                orb_next  = store_q;
                rpos_next = rpos_reg + 1'b1;
                fill_next = fill_reg - 1'b1;
                if (cmd_reg.kind == ttyld_pkg::CMD_READ_CANON) begin
                    lq_we    = 1'b1;
                    lq_waddr = qtail_reg;
                    lq_wdata = qdec;
                    if (qdec == '0) begin
                        olend_next = 1'b1;
                        qtail_next = qtail_reg + 1'b1;
                        qcnt_next  = qcnt_reg - 1'b1;
                    end
                end
            end
            ttyld_pkg::S_OUT: if (m_tready && !last_k) k_next = k_reg + 2'd1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ttyld_pkg::S_IDLE;
            rpos_reg  <= '0;
            fill_reg  <= '0;
            elen_reg  <= '0;
            qhead_reg <= '0;
            qtail_reg <= '0;
            qcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            rpos_reg  <= rpos_next;
            fill_reg  <= fill_next;
            elen_reg  <= elen_next;
            qhead_reg <= qhead_next;
            qtail_reg <= qtail_next;
            qcnt_reg  <= qcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        cidx_reg  <= cidx_next;
        qlen_reg  <= qlen_next;
        ost_reg   <= ost_next;
        nec_reg   <= nec_next;
        k_reg     <= k_next;
        orv_reg   <= orv_next;
        orb_reg   <= orb_next;
        olend_reg <= olend_next;
    end

    assign m_tvalid = (state_reg == ttyld_pkg::S_OUT);
    assign m_tlast  = last_k;
    assign m_tdata  = {olend_reg, orb_reg, orv_reg,
                       (cmd_reg.kind == ttyld_pkg::CMD_SIGNAL) ? cmd_reg.sig_kind : 2'd0,
                       cmd_reg.kind == ttyld_pkg::CMD_SIGNAL,
                       echo_v ? ttyld_pkg::echo_char(cmd_reg, k_reg) : 8'd0,
                       echo_v, ost_reg};

    assign stat.fill     = fill_reg;
    assign stat.edit_len = elen_reg;
    assign stat.qcount   = qcnt_reg;

endmodule

>>> hw/rtl/tty_input_line_discipline.sv
// Top level of the terminal input line discipline
//
// Input requests arrive on the s_ channel: s_tuser[0] selects receive (0) or read (1),
// s_tdata carries the received byte. The front end classifies each request against
// the configuration registers and queues it; the back end carries it out and sends
// one to three result requests on the m_ channel, the final one marked by m_tlast.
// Configuration is written via cfg_wr_en/cfg_index/cfg_wdata while idle; the user ensures it.
//
// Sequence: the back end pops a request in S_IDLE, carries it out in S_EXEC and sends
// its results from S_OUT until the receiver takes the last one. A read with data passes
// S_RD_WAIT, a canonical read S_QWAIT before it, for the registered store and line-length
// reads. A canonical commit copies the edit line into the store through one shared memory
// port, a read and a write state per line byte, then the closing write: the worst case.
// Reset (synchronous, aresetn low) empties the store, the edit line and the line
// queue by clearing their pointers and counts and reloads the register defaults;
// no memory clearing pass is needed.
// When the receiver stalls, the result holds on m_tdata; the command queue keeps
// taking up to four requests before s_tready falls.
`include "tty_input_line_discipline_defines.svh"

module tty_input_line_discipline (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [2] echo_valid, [10:3] echo_byte, [11] signal_valid,
    // [13:12] signal_kind, [14] read_valid, [22:15] read_byte, [23] line_end
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    ttyld_pkg::cmd_t       q_din, q_dout;
    logic                  q_push, q_pop, q_full, q_empty;
    ttyld_pkg::back_stat_t stat;

    // Accept and classify requests
    ttyld_front u_front (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .q_full, .q_push, .q_din
    );

    // Decouple the two halves
    ttyld_cmd_fifo u_fifo (
        .aclk, .aresetn, .push(q_push), .din(q_din), .pop(q_pop),
        .dout(q_dout), .full(q_full), .empty(q_empty)
    );

    // Execute commands and drive the result channel
    ttyld_back u_back (
        .aclk, .aresetn, .q_empty, .q_dout, .q_pop,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .stat
    );

    `TTYLD_ASSERT_ALWAYS(a_fill_bound, stat.fill <= ttyld_pkg::FW'(ttyld_pkg::STORE_DEPTH), "store overfilled")
    `TTYLD_ASSERT_ALWAYS(a_qcount_bound, stat.qcount <= ttyld_pkg::QCW'(ttyld_pkg::LINE_SLOTS), "line queue overfilled")
    `TTYLD_ASSERT_NEXT(a_last_ends_run, m_tvalid && m_tready && m_tlast, !m_tvalid, "result run did not end")

endmodule

>>> sim/tb_tty_input_line_discipline.sv
// Testbench for the terminal input line discipline: directed and random requests, scoreboarded results
`timescale 1ns / 1ps

import ttyld_pkg::*;

typedef struct packed {
    logic [1:0] status;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       signal_valid;
    logic [1:0] signal_kind;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       line_end;
    logic       last;
} tty_result_t;

// Scoreboard: a model of the line discipline plus the queue of results it predicts
class tty_scoreboard;
    logic [5:0]  flags;
    logic [7:0]  intr_ch, quit_ch, susp_ch, eof_ch;
    logic [7:0]  store [STORE_DEPTH];
    int          rd_pos, fill;
    logic [7:0]  edit [LINE_DEPTH + 1];
    int          edit_len;
    int          lq_len [LINE_SLOTS];
    int          q_head, q_tail, q_count;
    tty_result_t pending [$];
    int          mismatches;

    function void reset_state();
        flags = RST_FLAGS; intr_ch = RST_INTR; quit_ch = RST_QUIT;
        susp_ch = RST_SUSP; eof_ch = RST_EOF;
        rd_pos = 0; fill = 0; edit_len = 0; q_head = 0; q_tail = 0; q_count = 0;
        pending.delete();
        mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] val);
        case (idx)
            CFG_INPUT_FLAGS: flags = val[5:0];
            CFG_INTR_CHAR:   intr_ch = val;
            CFG_QUIT_CHAR:   quit_ch = val;
            CFG_SUSP_CHAR:   susp_ch = val;
            CFG_EOF_CHAR:    eof_ch = val;
            default: ;
        endcase
    endfunction

    function void push_byte(logic [7:0] v);
        store[(rd_pos + fill) % STORE_DEPTH] = v;
        fill++;
    endfunction

    function logic [7:0] pop_byte();
        logic [7:0] v;
        v = store[rd_pos];
        rd_pos = (rd_pos + 1) % STORE_DEPTH;
        fill--;
        return v;
    endfunction

    // Note an accepted request and queue the results it should cause
    function void note_request(logic is_read, logic [7:0] rx);
        logic [7:0]  echo [3];
        logic [7:0]  b;
        int          n_echo, cnt, need;
        tty_result_t r;
        logic        canon;
        r = '0;
        n_echo = 0;
        b = rx;
        canon = flags[FL_CANON];
        if (!is_read) begin
            if (!(flags[FL_IGNCR] && b == CH_CR)) begin
                if (flags[FL_ICRNL] && b == CH_CR) b = CH_NL;
                else if (flags[FL_INLCR] && b == CH_NL) b = CH_CR;
                if (flags[FL_ISIG] && (b == intr_ch || b == quit_ch || b == susp_ch)) begin
                    r.signal_valid = 1'b1;
                    if (b == intr_ch) begin
                        r.signal_kind = SIG_INTR; echo[1] = CH_C;
                    end else if (b == quit_ch) begin
                        r.signal_kind = SIG_QUIT; echo[1] = CH_BSL;
                    end else begin
                        r.signal_kind = SIG_SUSP; echo[1] = CH_Z;
                    end
                    echo[0] = CH_CARET; echo[2] = CH_NL;
                    if (flags[FL_ECHO]) n_echo = 3;
                    rd_pos = 0; fill = 0; edit_len = 0;
                    q_head = 0; q_tail = 0; q_count = 0;
                end else if (!canon) begin
                    if (fill >= STORE_DEPTH) r.status = ST_NO_ROOM;
                    else begin
                        push_byte(b);
                        echo[0] = b;
                        if (flags[FL_ECHO]) n_echo = 1;
                    end
                end else if (b == CH_BS || b == CH_DEL) begin
                    if (edit_len > 0) begin
                        edit_len--;
                        echo[0] = CH_BS; echo[1] = CH_SPACE; echo[2] = CH_BS;
                        if (flags[FL_ECHO]) n_echo = 3;
                    end
                end else if (b == eof_ch || b == CH_NL) begin
                    need = edit_len + ((b == CH_NL) ? 1 : 0);
                    if (need > STORE_DEPTH - fill || q_count >= LINE_SLOTS)
                        r.status = ST_NO_ROOM;
                    else begin
                        if (b == CH_NL && edit_len <= LINE_DEPTH) begin
                            edit[edit_len] = b;
                            edit_len++;
                        end
                        for (int i = 0; i < edit_len; i++) push_byte(edit[i]);
                        lq_len[q_head] = edit_len;
                        q_head = (q_head + 1) % LINE_SLOTS;
                        q_count++;
                        edit_len = 0;
                    end
                end else if (edit_len >= LINE_DEPTH) begin
                    r.status = ST_NO_ROOM;
                end else begin
                    edit[edit_len] = b;
                    edit_len++;
                    echo[0] = b;
                    if (flags[FL_ECHO]) n_echo = 1;
                end
            end
        end else if (canon) begin
            if (q_count == 0) r.status = ST_EMPTY;
            else begin
                if (lq_len[q_tail] == 0) r.line_end = 1'b1;
                else if (fill == 0) r.status = ST_EMPTY;
                else begin
                    r.read_byte = pop_byte();
                    r.read_valid = 1'b1;
                    lq_len[q_tail]--;
                    if (lq_len[q_tail] == 0) r.line_end = 1'b1;
                end
                if (r.line_end) begin
                    q_tail = (q_tail + 1) % LINE_SLOTS;
                    q_count--;
                end
            end
        end else begin
            if (fill == 0) r.status = ST_EMPTY;
            else begin
                r.read_byte = pop_byte();
                r.read_valid = 1'b1;
            end
        end
        cnt = (n_echo > 0) ? n_echo : 1;
        for (int k = 0; k < cnt; k++) begin
            r.echo_valid = (k < n_echo);
            r.echo_byte = (k < n_echo) ? echo[k] : 8'h00;
            r.last = (k == cnt - 1);
            pending.push_back(r);
        end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(tty_result_t got);
        tty_result_t exp_r;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected %h, got %h", exp_r, got);
        end
    endfunction
endclass

module tb_tty_input_line_discipline;
    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    tty_scoreboard sb;
    bit            idle_on;   // random idling on both sides when set

    tty_input_line_discipline dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit: far beyond the slowest correct run
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: stall at random, check every accepted result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result({m_tdata[1:0], m_tdata[2], m_tdata[10:3], m_tdata[11],
                                 m_tdata[13:12], m_tdata[14], m_tdata[22:15],
                                 m_tdata[23], m_tlast});
            m_tready <= !(idle_on && $urandom_range(99) < 36);
        end
    end

    // Write one register; only called with nothing in flight
    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one request and hold it until the block takes it
    task automatic send_request(logic is_read, logic [7:0] rx);
        while (idle_on && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_read;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(is_read, rx);
    endtask

    // Drop the request line, wait for every predicted result, then let a commit copy drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (2 * LINE_DEPTH + 50) @(posedge aclk);
    endtask

    task automatic recv(logic [7:0] b);
        send_request(1'b0, b);
    endtask

    task automatic rd();
        send_request(1'b1, 8'($urandom_range(255)));
    endtask

    // A short typed line with an occasional erase, ended by newline or end-of-file
    task automatic typed_line();
        int n;
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) recv(CH_DEL);
            else recv(8'($urandom_range(8'h20, 8'h7E)));
        end
        recv(($urandom_range(3) == 0) ? sb.eof_ch : CH_NL);
    endtask

    initial begin
        int accepted;
        sb = new();
        sb.reset_state();
        idle_on   = 1'b0;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_INPUT_FLAGS;
        cfg_wdata = 8'h00;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings are canonical, echo, CR to NL
        rd();                       // nothing readable
        recv(8'h00); recv(8'hFF);   // byte extremes
        recv(CH_BS); recv(CH_BS); recv(CH_BS); // last erase hits an empty line
        recv(8'h41); recv(CH_CR);   // CR becomes NL and commits
        recv(RST_EOF);              // empty end-of-file line
        rd(); rd(); rd(); rd();     // two bytes, the empty line, then an empty read
        recv(8'h61); recv(RST_INTR); // signals off: the interrupt character is only a line byte
        rd();
        drain();
        write_reg(CFG_INPUT_FLAGS, 8'h0D);  // raw, no echo, ignore CR, NL to CR, signals
        write_reg(CFG_INTR_CHAR, 8'h55);
        write_reg(CFG_QUIT_CHAR, 8'h55);    // equal to interrupt: interrupt wins
        write_reg(CFG_SUSP_CHAR, 8'hFF);
        write_reg(CFG_EOF_CHAR, 8'h00);
        write_reg(3'd7, 8'hAA);             // index beyond the list
        recv(CH_CR); recv(CH_NL); recv(8'h55); recv(8'hFF);
        recv(8'h12); rd(); rd();
        drain();
        write_reg(CFG_INPUT_FLAGS, 8'h3F);  // every flag set
        write_reg(CFG_INTR_CHAR, 8'h00);
        write_reg(CFG_QUIT_CHAR, 8'hFF);
        write_reg(CFG_SUSP_CHAR, 8'h1A);
        write_reg(CFG_EOF_CHAR, 8'hFF);     // shadowed by quit
        recv(8'hFF); recv(8'h1A);
        drain();

        // Random phases through several settings
        idle_on = 1'b1;
        accepted = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_INPUT_FLAGS, (ph == 0) ? 8'h00 : ((ph == 5) ? 8'h3F
                                                              : 8'($urandom_range(63))));
            write_reg(CFG_INTR_CHAR, RST_INTR);
            write_reg(CFG_QUIT_CHAR, RST_QUIT);
            write_reg(CFG_SUSP_CHAR, RST_SUSP);
            write_reg(CFG_EOF_CHAR, RST_EOF);
            if (ph == 3) idle_on = 1'b0;    // one stretch with no idling
            else idle_on = 1'b1;
            for (int j = 0; j < 5; j++) begin
                case ($urandom_range(9))
                    0: recv(8'($urandom_range(255)));
                    1, 2: rd();
                    default: begin
                        if (sb.flags[FL_CANON]) typed_line();
                        else recv(8'($urandom_range(255)));
                    end
                endcase
                repeat ($urandom_range(3)) rd();
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ttyld_pkg.sv
hw/rtl/ttyld_front.sv
hw/rtl/ttyld_cmd_fifo.sv
hw/rtl/ttyld_back.sv
hw/rtl/tty_input_line_discipline.sv
sim/tb_tty_input_line_discipline.sv
